@@ rtl/sortable_fifo_queue_top_assert.svh @@
// Assertion macros for the sortable FIFO queue.
`ifndef SORTABLE_FIFO_QUEUE_TOP_ASSERT_SVH
`define SORTABLE_FIFO_QUEUE_TOP_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define SFQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfq assertion failed");

// Clocked check that a condition never occurs, disabled while reset is asserted.
`define SFQ_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("sfq forbidden condition seen");

`endif

@@ rtl/sfq_pkg.sv @@
// Shared types and constants for the sortable FIFO queue.
`timescale 1ns / 1ps
package sfq_pkg;

  localparam int ModeW  = 2;
  localparam int ValueW = 16;
  localparam int StatW  = 2;
  localparam int OccW   = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SORT   = 2'd1,
    MODE_SERVE  = 2'd2
  } mode_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_INSERT,
    CELL_SORT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctrl_t;

endpackage

@@ rtl/sfq_cell.sv @@
// One storage cell of the queue: holds an entry, shifts, loads or swaps with a neighbor.
`timescale 1ns / 1ps
module sfq_cell #(
  parameter int Idx   = 0,
  parameter int Depth = 16,
  parameter int CntW  = 5
) (
  input  logic                       clk_i,
  input  sfq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CntW-1:0]            count_i,
  input  logic [sfq_pkg::ValueW-1:0] ins_i,
  input  logic [sfq_pkg::ValueW-1:0] left_i,
  input  logic [sfq_pkg::ValueW-1:0] right_i,
  output logic [sfq_pkg::ValueW-1:0] val_o
);
  import sfq_pkg::*;

  localparam logic [CntW-1:0] IdxC   = CntW'(Idx);
  localparam logic [CntW-1:0] IdxP1C = CntW'(Idx + 1);
  localparam logic            Parity = 1'(Idx % 2);
  localparam bit              IsLast = (Idx == Depth - 1);
  localparam bit              IsFirst = (Idx == 0);

  logic [ValueW-1:0] val_q, val_d;
  logic              is_left;

  always_comb begin
    val_d   = val_q;
    is_left = (Parity == ctrl_i.phase);
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (count_i == IdxC) val_d = ins_i;
      end
      CELL_SHIFT: begin
        if (!IsLast) val_d = right_i;
      end
      CELL_SORT: begin
        if (is_left) begin
          if (!IsLast && (IdxP1C < count_i) && (right_i > val_q)) val_d = right_i;
        end else begin
          if (!IsFirst && (IdxC < count_i) && (left_i < val_q)) val_d = left_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ rtl/sortable_fifo_queue_top.sv @@
// Top level of the sortable FIFO queue: control sequencer, count and result register.
// Insert, serve and unused modes: the result is registered at the clock edge that takes the request.
// Sort: DEPTH odd-even exchange passes over the cell row, the last repeated until the result is loaded.
// One request in flight at a time; the next is taken once the result register is free.
// Reset clears count, sequencer and result valid; cell contents are undefined until written.
`timescale 1ns / 1ps
module sortable_fifo_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sfq_pkg::ModeW-1:0]  mode_i,
  input  logic [sfq_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sfq_pkg::ValueW-1:0] served_value_o,
  output logic [sfq_pkg::StatW-1:0]  status_o,
  output logic [sfq_pkg::OccW-1:0]   occupancy_o
);
  import sfq_pkg::*;
  `include "sortable_fifo_queue_top_assert.svh"

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int PassW = $clog2(DEPTH);
  localparam logic [CntW-1:0]  DepthC   = CntW'(DEPTH);
  localparam logic [PassW-1:0] LastPass = PassW'(DEPTH - 1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PassW-1:0]  pass_q, pass_d;
  cell_ctrl_t        ctrl;
  logic              out_free, out_load;
  logic [ValueW-1:0] res_served;
  status_e           res_status;

  logic              out_valid_q;
  logic [ValueW-1:0] served_q;
  status_e           status_q;
  logic [OccW-1:0]   occ_q;

  logic [ValueW-1:0] cell_val [DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    ctrl.op    = CELL_HOLD;
    ctrl.phase = pass_q[0];
    out_load   = 1'b0;
    res_served = '0;
    res_status = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          case (mode_e'(mode_i))
            MODE_INSERT: begin
              out_load = 1'b1;
              if (cnt_q == DepthC) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            MODE_SERVE: begin
              out_load = 1'b1;
              if (cnt_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                ctrl.op    = CELL_SHIFT;
                res_served = cell_val[0];
                cnt_d      = cnt_q - 1'b1;
              end
            end
            MODE_SORT: begin
              state_d = ST_SORT;
              pass_d  = '0;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_SORT: begin
        ctrl.op = CELL_SORT;
        if (pass_q == LastPass) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          pass_d = pass_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      served_q <= res_served;
      status_q <= res_status;
      occ_q    <= OccW'(cnt_d);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    sfq_cell #(
      .Idx  (i),
      .Depth(DEPTH),
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(cnt_q),
      .ins_i  (value_i),
      .left_i (left_v),
      .right_i(right_v),
      .val_o  (cell_val[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign served_value_o = served_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;

  `SFQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= DepthC)
  `SFQ_ASSERT(a_sort_blocks, clk_i, rst_ni, (state_q == ST_SORT) |-> !in_ready_o)
  `SFQ_ASSERT(a_empty_cnt, clk_i, rst_ni,
              (out_valid_q && status_q == STAT_EMPTY) |-> (cnt_q == '0))
  `SFQ_ASSERT(a_served_ok, clk_i, rst_ni,
              (out_valid_q && served_q != '0) |-> (status_q == STAT_OK))
  `SFQ_ASSERT_NEVER(a_ready_blocked, clk_i, rst_ni, in_ready_o && out_valid_q && !out_ready_i)

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the sortable FIFO queue: predictor, stimulus and result checks.
`timescale 1ns / 1ps
module tb;
  import sfq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ValueW-1:0] served;
    logic [StatW-1:0]  status;
    logic [OccW-1:0]   occ;
  } queue_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b1;
  logic              in_valid_i  = 1'b0;
  logic [ModeW-1:0]  mode_i      = MODE_INSERT;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [ValueW-1:0] served_value_o;
  logic [StatW-1:0]  status_o;
  logic [OccW-1:0]   occupancy_o;

  logic [ValueW-1:0] model_entries[$];
  queue_result_t     expected_results[$];
  queue_result_t     oldest_result;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                requests_sent = 0;
  int                results_checked = 0;
  int                full_flags = 0;
  int                empty_flags = 0;
  int                sorts_done = 0;
  int                fail_count = 0;
  int                quiet_cycles = 0;

  sortable_fifo_queue_top #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .served_value_o(served_value_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic queue_result_t predict_queue_op(input logic [ModeW-1:0] m,
                                                     input logic [ValueW-1:0] v);
    queue_result_t     res;
    logic [ValueW-1:0] key;
    int                j;
    res = '0;
    res.status = STAT_OK;
    case (m)
      MODE_INSERT: begin
        if (model_entries.size() >= DEPTH) begin
          res.status = STAT_FULL;
          full_flags++;
        end else begin
          model_entries.push_back(v);
        end
      end
      MODE_SORT: begin
        sorts_done++;
        for (int i = 1; i < model_entries.size(); i++) begin
          key = model_entries[i];
          j = i;
          while (j > 0 && model_entries[j-1] < key) begin
            model_entries[j] = model_entries[j-1];
            j--;
          end
          model_entries[j] = key;
        end
      end
      MODE_SERVE: begin
        if (model_entries.size() == 0) begin
          res.status = STAT_EMPTY;
          empty_flags++;
        end else begin
          res.served = model_entries.pop_front();
        end
      end
      default: ;
    endcase
    res.occ = OccW'(model_entries.size());
    return res;
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return ValueW'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      default: return ValueW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_request(input logic [ModeW-1:0] m, input logic [ValueW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(predict_queue_op(m, v));
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: served_value %0h status %0d occupancy %0d",
               served_value_o, status_o, occupancy_o);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (served_value_o !== oldest_result.served) begin
          $error("served_value: expected %0h, got %0h", oldest_result.served, served_value_o);
          fail_count++;
        end
        if (status_o !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, status_o);
          fail_count++;
        end
        if (occupancy_o !== oldest_result.occ) begin
          $error("occupancy: expected %0d, got %0d", oldest_result.occ, occupancy_o);
          fail_count++;
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // serve, sort and unused mode on an empty queue
  task automatic test_empty_queue();
    send_request(MODE_SERVE, 16'hFFFF);
    send_request(MODE_SORT, 16'h0000);
    send_request(MODE_UNUSED, 16'hFFFF);
  endtask

  task automatic test_basic_ops();
    send_request(MODE_INSERT, 16'h0000);
    send_request(MODE_SORT, 16'hAAAA);
    send_request(MODE_SERVE, 16'h5555);
    send_request(MODE_INSERT, 16'hFFFF);
    send_request(MODE_INSERT, 16'h0001);
    send_request(MODE_INSERT, 16'h8000);
    send_request(MODE_INSERT, 16'h7FFF);
    send_request(MODE_INSERT, 16'h8000);
    send_request(MODE_UNUSED, 16'h1234);
    send_request(MODE_SORT, 16'hFFFF);
    send_request(MODE_SERVE, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
  endtask

  // fill to capacity, overflow, unused mode, then sort and serve from a full queue
  task automatic test_full_queue();
    while (model_entries.size() < DEPTH) send_request(MODE_INSERT, pick_value());
    send_request(MODE_INSERT, 16'hFFFF);
    send_request(MODE_UNUSED, 16'h0000);
    send_request(MODE_SORT, 16'h0000);
    send_request(MODE_SERVE, 16'h0000);
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    int pick;
    start = requests_sent;
    while (requests_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          while (model_entries.size() < DEPTH) send_request(MODE_INSERT, pick_value());
          repeat ($urandom_range(1, 2)) send_request(MODE_INSERT, pick_value());
        end
        2, 3: begin
          while (model_entries.size() > 0) send_request(MODE_SERVE, pick_value());
          send_request(MODE_SERVE, pick_value());
        end
        4, 5: begin
          send_request(MODE_SORT, pick_value());
          repeat ($urandom_range(1, 4)) send_request(MODE_SERVE, pick_value());
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) send_request(MODE_INSERT, pick_value());
            else if (pick < 6) send_request(MODE_SORT, pick_value());
            else if (pick < 9) send_request(MODE_SERVE, pick_value());
            else send_request(MODE_UNUSED, pick_value());
          end
        end
      endcase
    end
  endtask

  // sender holds off until every outstanding request has completed
  task automatic test_drain_pause();
    repeat (3) send_request(MODE_INSERT, pick_value());
    send_request(MODE_SORT, pick_value());
    wait_for_drain();
    send_request(MODE_SERVE, pick_value());
    send_request(MODE_SORT, pick_value());
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 61;
    test_empty_queue();
    test_basic_ops();
    test_full_queue();
    test_random_traffic(560);
    test_drain_pause();

    send_idle_pct = 61;
    recv_idle_pct = 18;
    test_random_traffic(560);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);
    test_drain_pause();

    wait_for_drain();
    repeat (2 * DEPTH) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end

    $display("Sent %0d requests (%0d sorts) under three idle mixes, checked %0d results.",
             requests_sent, sorts_done, results_checked);
    $display("Full-queue inserts rejected: %0d, empty-queue serves flagged: %0d.",
             full_flags, empty_flags);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
